### hw/rtl/lcfe_pkg.sv
// Shared types and constants for the LED channel fade engine.
`default_nettype none
package lcfe_pkg;

  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned STEPS_W  = 8;
  localparam int unsigned PERIOD_W = 18;
  localparam int unsigned CHIDX_W  = 6;
  localparam int unsigned LED_W    = 5;
  localparam int unsigned MASK_W   = 16;
  localparam int unsigned TIME_W   = 8;
  localparam int unsigned SCALE_W  = 10;
  localparam logic [SCALE_W-1:0] TIME_SCALE = 10'd1000;

  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_FADE   = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] SUB_BLUE  = 2'd0;
  localparam logic [1:0] SUB_GREEN = 2'd1;
  localparam logic [1:0] SUB_RED   = 2'd2;

  typedef struct packed {
    logic [LEVEL_W-1:0]  level;
    logic [STEPS_W-1:0]  steps;
    logic                down;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] cd;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_EX   = 4'b0100,
    S_DIV  = 4'b1000
  } state_t;

endpackage
`default_nettype wire

### hw/rtl/led_channel_fade_engine.sv
// Top level of the LED channel fade engine: channel memory and sequencer.
//
// Command channel: a transaction is taken when start is high and busy is low.
// in_mode 0 sets the color of the LEDs selected by in_led_mask and dumps all
// channels; mode 1 starts a linear fade on the selected LEDs and emits
// nothing; mode 2 is a tick that steps or counts down every channel and then
// dumps all channels; mode 3 does nothing.
// A dump is 3*LED_COUNT results, channel 0 first, each on the out_ ports for
// one cycle marked by out_strobe; out_last marks the final channel.
// Set, fade and tick commands walk all channels through one entry of the
// channel memory each: read, modify, write back. In a fade start, each
// selected channel with a nonzero step count also runs the shared divider
// before its write-back. busy stays high throughout.
// The receiver cannot stall; results leave at the rate they are produced.
// Reset clears the per-entry valid bits, so every channel reads as zero
// until written; no clearing pass is needed.
`default_nettype none
module led_channel_fade_engine #(
  parameter int unsigned LED_COUNT = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     in_mode,
  input  wire logic [lcfe_pkg::MASK_W-1:0]    in_led_mask,
  input  wire logic [lcfe_pkg::LEVEL_W-1:0]   in_red,
  input  wire logic [lcfe_pkg::LEVEL_W-1:0]   in_green,
  input  wire logic [lcfe_pkg::LEVEL_W-1:0]   in_blue,
  input  wire logic [lcfe_pkg::TIME_W-1:0]    in_fade_time,
  output logic                                out_strobe,
  output logic [lcfe_pkg::CHIDX_W-1:0]        out_channel_index,
  output logic [lcfe_pkg::LEVEL_W-1:0]        out_level,
  output logic                                out_last
);
  import lcfe_pkg::*;

  localparam int unsigned CH = 3 * LED_COUNT;
  localparam int unsigned AW = $clog2(CH);

  entry_t              mem [CH];
  logic [CH-1:0]       vld_r;
  entry_t              rd_r;
  logic                rd_vld_r;
  entry_t              cur;

  state_t              state_r, state_nxt;
  logic [CHIDX_W-1:0]  ch_r, ch_nxt;
  logic [LED_W-1:0]    led_r, led_nxt;
  logic [1:0]          sub_r, sub_nxt;

  logic [1:0]          mode_r;
  logic [MASK_W-1:0]   mask_r;
  logic [LEVEL_W-1:0]  red_r, green_r, blue_r;
  logic [PERIOD_W-1:0] dur_r;
  logic [SCALE_W+TIME_W-1:0] dur_full;

  entry_t              pend_r, pend_nxt;
  entry_t              wr_data;
  logic                wr_en;

  logic                div_go, div_done;
  logic [PERIOD_W-1:0] div_q;

  logic                sel;
  logic [LEVEL_W-1:0]  target;
  logic                last_ch;
  logic                ostb_nxt;
  entry_t              upd;

  logic                ostb_r;
  logic [CHIDX_W-1:0]  och_r;
  logic [LEVEL_W-1:0]  olvl_r;
  logic                olast_r;

  lcfe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (dur_r),
    .divisor  (pend_nxt.steps),
    .done     (div_done),
    .quotient (div_q)
  );

  assign dur_full = TIME_SCALE * in_fade_time;
  assign cur      = rd_vld_r ? rd_r : '0;
  assign sel      = !led_r[LED_W-1] && mask_r[led_r[3:0]];
  assign last_ch  = (ch_r == CHIDX_W'(CH - 1));

  always_comb begin
    case (sub_r)
      SUB_BLUE:  target = blue_r;
      SUB_GREEN: target = green_r;
      SUB_RED:   target = red_r;
      default:   target = red_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    led_nxt   = led_r;
    sub_nxt   = sub_r;
    pend_nxt  = pend_r;
    wr_en     = 1'b0;
    wr_data   = cur;
    div_go    = 1'b0;
    ostb_nxt  = 1'b0;
    upd       = cur;

    case (mode_r)
      MODE_SET: begin
        if (sel) upd.level = target;
      end
      MODE_FADE: begin
        if (sel) begin
          upd.down   = cur.level > target;
          upd.steps  = upd.down ? cur.level - target : target - cur.level;
          upd.cd     = '0;
          upd.period = '0;
        end
      end
      MODE_TICK: begin
        if (cur.steps != '0 && cur.cd == '0) begin
          upd.steps = cur.steps - 8'd1;
          upd.cd    = cur.period;
          upd.level = cur.down ? cur.level - 8'd1 : cur.level + 8'd1;
        end else if (cur.cd != '0) begin
          upd.cd = cur.cd - 18'd1;
        end
      end
      default: upd = cur;
    endcase

    case (state_r)
      S_IDLE: begin
        if (start) begin
          ch_nxt  = '0;
          led_nxt = '0;
          sub_nxt = SUB_BLUE;
          state_nxt = (in_mode == MODE_SET || in_mode == MODE_FADE || in_mode == MODE_TICK)
                      ? S_RD : S_IDLE;
        end
      end
      S_RD: begin
        state_nxt = S_EX;
      end
      S_EX: begin
        if (mode_r == MODE_FADE && sel && upd.steps != '0) begin
          pend_nxt  = upd;
          div_go    = 1'b1;
          state_nxt = S_DIV;
        end else begin
          wr_en     = 1'b1;
          wr_data   = upd;
          ostb_nxt  = (mode_r != MODE_FADE);
          state_nxt = last_ch ? S_IDLE : S_RD;
        end
      end
      S_DIV: begin
        if (div_done) begin
          wr_en          = 1'b1;
          wr_data        = pend_r;
          wr_data.period = div_q;
          state_nxt      = last_ch ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if ((state_r == S_EX && state_nxt != S_DIV) || (state_r == S_DIV && div_done)) begin
      ch_nxt = ch_r + 6'd1;
      if (sub_r == SUB_RED) begin
        sub_nxt = SUB_BLUE;
        led_nxt = led_r + 5'd1;
      end else begin
        sub_nxt = sub_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[ch_r[AW-1:0]] <= wr_data;
    rd_r <= mem[ch_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      ostb_r   <= 1'b0;
      ch_r     <= '0;
      led_r    <= '0;
      sub_r    <= SUB_BLUE;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= vld_r[ch_r[AW-1:0]];
      if (wr_en) vld_r[ch_r[AW-1:0]] <= 1'b1;
      ostb_r   <= ostb_nxt;
      ch_r     <= ch_nxt;
      led_r    <= led_nxt;
      sub_r    <= sub_nxt;
    end
    pend_r  <= pend_nxt;
    och_r   <= ch_r;
    olvl_r  <= upd.level;
    olast_r <= last_ch;
    if (state_r == S_IDLE && start) begin
      mode_r  <= in_mode;
      mask_r  <= in_led_mask;
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
      dur_r   <= dur_full[PERIOD_W-1:0];
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_strobe        = ostb_r;
  assign out_channel_index = och_r;
  assign out_level         = olvl_r;
  assign out_last          = olast_r;

endmodule
`default_nettype wire

### hw/rtl/lcfe_div.sv
// Restoring divider: 18-bit dividend by 8-bit divisor, one quotient bit per cycle.
`default_nettype none
module lcfe_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           go,
  input  wire logic [lcfe_pkg::PERIOD_W-1:0]  dividend,
  input  wire logic [lcfe_pkg::STEPS_W-1:0]   divisor,
  output logic                                done,
  output logic [lcfe_pkg::PERIOD_W-1:0]       quotient
);
  import lcfe_pkg::*;

  logic                    run_r, run_nxt;
  logic [4:0]              cnt_r, cnt_nxt;
  logic [STEPS_W-1:0]      rem_r, rem_nxt;
  logic [PERIOD_W-1:0]     quo_r, quo_nxt;
  logic [STEPS_W-1:0]      dsr_r, dsr_nxt;
  logic                    done_r, done_nxt;
  logic [STEPS_W:0]        trial;
  logic [STEPS_W:0]        diff;

  always_comb begin
    trial    = {rem_r, quo_r[PERIOD_W-1]};
    diff     = trial - {1'b0, dsr_r};
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    done_nxt = 1'b0;
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      quo_nxt = dividend;
      dsr_nxt = divisor;
    end else if (run_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = diff[STEPS_W-1:0];
        quo_nxt = {quo_r[PERIOD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[STEPS_W-1:0];
        quo_nxt = {quo_r[PERIOD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(PERIOD_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

### bench/tb.sv
// Self-checking bench for the LED channel fade engine: set, fade and tick transactions.
`default_nettype none
import lcfe_pkg::*;

class fade_scoreboard;
  localparam int CHANS = 48;
  bit [7:0]  lvl [CHANS];
  bit [7:0]  steps [CHANS];
  bit        down [CHANS];
  bit [17:0] period [CHANS];
  bit [17:0] cd [CHANS];
  bit [7:0]  exp_level [$];
  bit [5:0]  exp_chan [$];
  int errors;
  int dumps;

  function void clear_state();
    for (int c = 0; c < CHANS; c++) begin
      lvl[c] = 0; steps[c] = 0; down[c] = 0; period[c] = 0; cd[c] = 0;
    end
  endfunction

  function void queue_levels();
    for (int c = 0; c < CHANS; c++) begin
      exp_chan.push_back(c[5:0]);
      exp_level.push_back(lvl[c]);
    end
    dumps++;
  endfunction

  function void note_command(bit [1:0] mode, bit [15:0] mask, bit [7:0] r, bit [7:0] g,
                             bit [7:0] b, bit [7:0] t);
    bit [7:0] tgt [3];
    bit [17:0] dur;
    int c;
    tgt[0] = b; tgt[1] = g; tgt[2] = r;
    dur = 18'(t) * 18'd1000;
    if (mode == MODE_SET) begin
      for (int i = 0; i < 16; i++)
        if (mask[i]) for (int k = 0; k < 3; k++) lvl[3*i+k] = tgt[k];
      queue_levels();
    end else if (mode == MODE_FADE) begin
      for (int i = 0; i < 16; i++)
        if (mask[i])
          for (int k = 0; k < 3; k++) begin
            c = 3*i+k;
            down[c] = lvl[c] > tgt[k];
            steps[c] = down[c] ? lvl[c] - tgt[k] : tgt[k] - lvl[c];
            cd[c] = 0;
            period[c] = (steps[c] != 0) ? dur / steps[c] : 0;
          end
    end else if (mode == MODE_TICK) begin
      for (c = 0; c < CHANS; c++) begin
        if (steps[c] != 0 && cd[c] == 0) begin
          steps[c]--;
          cd[c] = period[c];
          lvl[c] = down[c] ? lvl[c] - 8'd1 : lvl[c] + 8'd1;
        end else if (cd[c] != 0) begin
          cd[c]--;
        end
      end
      queue_levels();
    end
  endfunction

  function void check_level(bit [5:0] ch, bit [7:0] level, bit last);
    bit [5:0] ec;
    bit [7:0] el;
    if (exp_chan.size() == 0) begin
      $error("unexpected result channel_index=%0d", ch);
      errors++;
      return;
    end
    ec = exp_chan.pop_front();
    el = exp_level.pop_front();
    if (ch != ec) begin
      $error("channel_index expected %0d actual %0d", ec, ch); errors++;
    end
    if (level != el) begin
      $error("level expected %0d actual %0d", el, level); errors++;
    end
    if (last != (ec == 6'd47)) begin
      $error("last expected %0d actual %0d", ec == 6'd47, last); errors++;
    end
  endfunction
endclass

module tb;
  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [1:0] in_mode = 0;
  logic [15:0] in_led_mask = 0;
  logic [7:0] in_red = 0, in_green = 0, in_blue = 0, in_fade_time = 0;
  logic out_strobe;
  logic [5:0] out_channel_index;
  logic [7:0] out_level;
  logic out_last;
  int idle_pct;
  int n_items;
  fade_scoreboard sb;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  led_channel_fade_engine u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_led_mask(in_led_mask), .in_red(in_red),
    .in_green(in_green), .in_blue(in_blue), .in_fade_time(in_fade_time),
    .out_strobe(out_strobe), .out_channel_index(out_channel_index),
    .out_level(out_level), .out_last(out_last)
  );

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_level(out_channel_index, out_level, out_last);
  end

  task automatic send_command(bit [1:0] m, bit [15:0] mask, bit [7:0] r, bit [7:0] g,
                              bit [7:0] b, bit [7:0] t);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1; in_mode <= m; in_led_mask <= mask;
    in_red <= r; in_green <= g; in_blue <= b; in_fade_time <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(m, mask, r, g, b, t);
    n_items++;
  endtask

  task automatic send_random();
    int p;
    bit [1:0] m;
    bit [7:0] t;
    p = $urandom_range(99);
    m = p < 25 ? MODE_SET : p < 45 ? MODE_FADE : p < 97 ? MODE_TICK : MODE_UNUSED;
    t = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(2));
    send_command(m, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), t);
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    idle_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_command(MODE_TICK, 0, 0, 0, 0, 0);
    send_command(MODE_SET, 16'hFFFF, 8'hFF, 8'h00, 8'hAA, 0);
    send_command(MODE_SET, 16'h0001, 8'h01, 8'h80, 8'h55, 8'hFF);
    send_command(MODE_UNUSED, 16'hFFFF, 8'h12, 8'h34, 8'h56, 8'h01);
    send_command(MODE_FADE, 16'hFFFF, 8'h00, 8'hFF, 8'hAB, 8'h00);
    repeat (3) send_command(MODE_TICK, 0, 0, 0, 0, 0);
    send_command(MODE_FADE, 16'h8001, 8'h02, 8'h7F, 8'hFF, 8'h01);
    repeat (3) send_command(MODE_TICK, 16'hFFFF, 0, 0, 0, 0);
    // color write mid-fade: later steps wrap
    send_command(MODE_SET, 16'h8001, 8'hFF, 8'h00, 8'hFF, 0);
    repeat (3) send_command(MODE_TICK, 0, 0, 0, 0, 0);
    send_command(MODE_FADE, 16'h5555, 8'h10, 8'h20, 8'h30, 8'hFF);
    repeat (3) send_command(MODE_TICK, 0, 0, 0, 0, 0);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = ph == 1 ? 76 : ph == 3 ? 12 : 0;
      repeat (33) send_random();
    end
    start <= 0;
    while (sb.exp_chan.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d transactions, %0d channel dumps checked", n_items, sb.dumps);
    $display("set, fade, tick and unused modes with idle gaps of 0, 12 and 76 percent");
    if (sb.errors == 0 && sb.exp_chan.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire
